// File: sv/pid_line_follow_steering_assert.svh
// Assertion macros for the line follower steering block.
`ifndef PID_LINE_FOLLOW_STEERING_ASSERT_SVH
`define PID_LINE_FOLLOW_STEERING_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define PLFS_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PLFS_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PLFS_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`define PLFS_ASSERT_NXT(name, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: sv/plfs_pkg.sv
// Shared types, constants and gain schedule for the line follower steering block.
package plfs_pkg;

  localparam int IntegralWidthDefault = 32;

  localparam int PosWidth    = 12;
  localparam int SensorWidth = 10;
  localparam int DriveWidth  = 8;
  localparam int InDataWidth  = 64;
  localparam int OutDataWidth = 24;

  localparam int CfgIdxWidth  = 2;
  localparam int CfgDataWidth = 10;

  localparam logic [CfgIdxWidth-1:0] RegMaxSpeed     = 2'd0;
  localparam logic [CfgIdxWidth-1:0] RegDeadEndLevel  = 2'd1;
  localparam logic [CfgIdxWidth-1:0] RegJunctionLevel = 2'd2;

  localparam logic [7:0] MaxSpeedReset      = 8'd100;
  localparam logic [9:0] DeadEndLevelReset  = 10'd100;
  localparam logic [9:0] JunctionLevelReset = 10'd200;

  localparam logic [PosWidth-1:0] PosMax    = 12'd4000;
  localparam logic [PosWidth-1:0] PosCenter = 12'd2000;

  localparam logic [13:0] IntegDiv = 14'd15000;

  // kp division is done as multiply by ceil(2^16 / kp), exact for |err| <= 2000
  localparam int RecipShift = 16;

  typedef enum logic [1:0] {
    SEG_FOLLOW   = 2'd0,
    SEG_DEAD_END = 2'd1,
    SEG_JUNCTION = 2'd2
  } seg_end_e;

  typedef struct packed {
    logic [13:0] kp_recip;
    logic [9:0]  kd;
  } gain_t;

  function automatic gain_t gain_lookup(input logic [7:0] max_speed);
    gain_t g;
    if (max_speed <= 8'd120) begin
      g.kp_recip = 14'd3277;
      g.kd       = 10'd384;
    end else if (max_speed <= 8'd150) begin
      g.kp_recip = 14'd4370;
      g.kd       = 10'd341;
    end else if (max_speed <= 8'd200) begin
      g.kp_recip = 14'd6554;
      g.kd       = 10'd341;
    end else if (max_speed <= 8'd220) begin
      g.kp_recip = 14'd10923;
      g.kd       = 10'd512;
    end else begin
      g.kp_recip = 14'd13108;
      g.kd       = 10'd576;
    end
    return g;
  endfunction

endpackage

// File: sv/pid_line_follow_steering.sv
// Line follower steering controller: PID steering and segment end detection.
//
// Usage:
//   Input channel s_axis carries one sensor frame per word: line position and
//   five reflectance readings. Output channel m_axis carries one result word
//   per frame: left drive, right drive and the segment end code.
//   Configuration is a plain write port (max speed, dead end level, junction
//   level); write it only while no frame is in flight.
// Timing:
//   A frame is registered on acceptance and its result is registered when
//   the frame advances out of the input register: m_axis_tvalid_o then
//   rises and the result word can be taken. One frame per clock is
//   sustained while m_axis_tready_i stays high; the controller state update
//   sits in the single compute stage between the input and result registers.
// Reset:
//   Both pipeline registers empty, configuration at its defaults, previous
//   error and integral cleared. A dead end or junction result also clears them.
// Stall:
//   When the receiver holds m_axis_tready_i low, the result word holds, the
//   input register fills, and s_axis_tready_o drops until the output drains.
`include "pid_line_follow_steering_assert.svh"

module pid_line_follow_steering #(
  parameter int INTEGRAL_WIDTH = plfs_pkg::IntegralWidthDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [plfs_pkg::CfgIdxWidth-1:0]    cfg_idx_i,
  input  logic [plfs_pkg::CfgDataWidth-1:0]   cfg_data_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // line_position, sensor_left_outer, sensor_left_inner, sensor_middle,
  // sensor_right_inner, sensor_right_outer, zero fill
  input  logic [plfs_pkg::InDataWidth-1:0]    s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // left_drive, right_drive, segment_end, zero fill
  output logic [plfs_pkg::OutDataWidth-1:0]   m_axis_tdata_o
);
  import plfs_pkg::*;

  localparam int W  = INTEGRAL_WIDTH;
  localparam int QW = W - 13;
  localparam int SW = ((QW > 15) ? QW : 15) + 2;

  localparam logic [W-1:0] IntMax = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] IntMin = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [QW-1:0] SatHiQ = QW'(IntMax / IntegDiv);
  localparam logic signed [14:0]   SatHiR = 15'(IntMax % IntegDiv);
  localparam logic signed [QW-1:0] SatLoQ = QW'(-(IntMin / IntegDiv));
  localparam logic signed [14:0]   SatLoR = 15'(-(IntMin % IntegDiv));
  localparam logic signed [15:0]   DivS   = $signed(16'(IntegDiv));

  // configuration
  logic [7:0] max_speed_q;
  logic [9:0] dead_end_level_q;
  logic [9:0] junction_level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q      <= MaxSpeedReset;
      dead_end_level_q <= DeadEndLevelReset;
      junction_level_q <= JunctionLevelReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegMaxSpeed:      max_speed_q      <= cfg_data_i[7:0];
        RegDeadEndLevel:  dead_end_level_q <= cfg_data_i;
        RegJunctionLevel: junction_level_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic in_v_q, out_v_q;
  logic advance;

  assign advance         = in_v_q && (!out_v_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_v_q || advance;
  assign m_axis_tvalid_o = out_v_q;

  // input register
  logic [PosWidth-1:0]    pos_q;
  logic [SensorWidth-1:0] s0_q, s1_q, s2_q, s3_q, s4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_v_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      pos_q <= s_axis_tdata_i[11:0];
      s0_q  <= s_axis_tdata_i[21:12];
      s1_q  <= s_axis_tdata_i[31:22];
      s2_q  <= s_axis_tdata_i[41:32];
      s3_q  <= s_axis_tdata_i[51:42];
      s4_q  <= s_axis_tdata_i[61:52];
    end
  end

  // controller state; integral also tracked as quotient and remainder by 15000
  logic signed [11:0]   prev_err_q;
  logic [W-1:0]         integ_q, integ_d;
  logic signed [QW-1:0] quo_q, quo_d;
  logic signed [14:0]   rem_q, rem_d;

  logic [PosWidth-1:0]  pos_c, pos_off;
  logic signed [11:0]   err, err_abs;
  logic signed [12:0]   der, der_abs;
  logic [10:0]          err_mag;
  logic [11:0]          der_mag;
  gain_t                gain;
  logic [24:0]          p_prod;
  logic [21:0]          d_prod;
  logic [8:0]           p_mag;
  logic [13:0]          d_mag;
  logic signed [9:0]    p_term;
  logic signed [14:0]   d_term;
  logic [W:0]           isum;
  logic                 sat_hi, sat_lo;
  logic signed [15:0]   rsum;
  logic signed [SW-1:0] steer, ms_s, steer_cl;
  logic signed [8:0]    steer_c;
  logic [7:0]           left_d, right_d;
  logic                 dead_end, junction;
  seg_end_e             seg_d;

  always_comb begin
    pos_c   = (pos_q > PosMax) ? PosMax : pos_q;
    pos_off = pos_c - PosCenter;
    err     = $signed(pos_off);
    der     = {err[11], err} - {prev_err_q[11], prev_err_q};
    err_abs = err[11] ? -err : err;
    der_abs = der[12] ? -der : der;
    err_mag = err_abs[10:0];
    der_mag = der_abs[11:0];

    gain   = gain_lookup(max_speed_q);
    p_prod = {3'b000, err_mag} * {11'd0, gain.kp_recip};
    p_mag  = p_prod[RecipShift+8:RecipShift];
    p_term = err[11] ? -$signed({1'b0, p_mag}) : $signed({1'b0, p_mag});
    d_prod = {10'd0, der_mag} * {12'd0, gain.kd};
    d_mag  = d_prod[21:8];
    d_term = der[12] ? -$signed({1'b0, d_mag}) : $signed({1'b0, d_mag});

    // saturating integral
    isum   = {integ_q[W-1], integ_q} + {{(W-11){err[11]}}, err};
    sat_hi = !isum[W] && isum[W-1];
    sat_lo = isum[W] && !isum[W-1];
    if (sat_hi) begin
      integ_d = IntMax;
    end else if (sat_lo) begin
      integ_d = IntMin;
    end else begin
      integ_d = isum[W-1:0];
    end

    // truncated quotient of the integral, one correction step per frame
    rsum = {rem_q[14], rem_q} + {{4{err[11]}}, err};
    if (sat_hi) begin
      quo_d = SatHiQ;
      rem_d = SatHiR;
    end else if (sat_lo) begin
      quo_d = SatLoQ;
      rem_d = SatLoR;
    end else if (rsum >= DivS) begin
      quo_d = quo_q + QW'(1);
      rem_d = 15'(rsum - DivS);
    end else if (rsum <= -DivS) begin
      quo_d = quo_q - QW'(1);
      rem_d = 15'(rsum + DivS);
    end else if (!integ_d[W-1] && rsum < 16'sd0) begin
      quo_d = quo_q - QW'(1);
      rem_d = 15'(rsum + DivS);
    end else if (integ_d[W-1] && rsum > 16'sd0) begin
      quo_d = quo_q + QW'(1);
      rem_d = 15'(rsum - DivS);
    end else begin
      quo_d = quo_q;
      rem_d = 15'(rsum);
    end

    steer = SW'(p_term) + SW'(quo_d) + SW'(d_term);
    ms_s  = $signed(SW'({1'b0, max_speed_q}));
    if (steer > ms_s) begin
      steer_cl = ms_s;
    end else if (steer < -ms_s) begin
      steer_cl = -ms_s;
    end else begin
      steer_cl = steer;
    end
    steer_c = steer_cl[8:0];

    if (steer_c[8]) begin
      left_d  = max_speed_q + steer_c[7:0];
      right_d = max_speed_q;
    end else begin
      left_d  = max_speed_q;
      right_d = max_speed_q - steer_c[7:0];
    end

    dead_end = (s1_q < dead_end_level_q) && (s2_q < dead_end_level_q)
               && (s3_q < dead_end_level_q);
    junction = (s0_q > junction_level_q) || (s4_q > junction_level_q);
    if (dead_end) begin
      seg_d = SEG_DEAD_END;
    end else if (junction) begin
      seg_d = SEG_JUNCTION;
    end else begin
      seg_d = SEG_FOLLOW;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_err_q <= '0;
      integ_q    <= '0;
      quo_q      <= '0;
      rem_q      <= '0;
    end else if (advance) begin
      if (seg_d != SEG_FOLLOW) begin
        prev_err_q <= '0;
        integ_q    <= '0;
        quo_q      <= '0;
        rem_q      <= '0;
      end else begin
        prev_err_q <= err;
        integ_q    <= integ_d;
        quo_q      <= quo_d;
        rem_q      <= rem_d;
      end
    end
  end

  // result register
  logic [7:0] left_q, right_q;
  seg_end_e   seg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (advance) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      left_q  <= left_d;
      right_q <= right_d;
      seg_q   <= seg_d;
    end
  end

  assign m_axis_tdata_o = {6'd0, seg_q, right_q, left_q};

  logic seg_hit, state_zero, rem_ok, drive_ok;

  assign seg_hit    = advance && (seg_d != SEG_FOLLOW);
  assign state_zero = (prev_err_q == 12'sd0) && (integ_q == '0) && (quo_q == '0)
                      && (rem_q == 15'sd0);
  assign rem_ok     = (rem_q < 15'sd15000) && (rem_q > -15'sd15000)
                      && (integ_q[W-1] ? (rem_q <= 15'sd0) : (rem_q >= 15'sd0));
  assign drive_ok   = (left_q <= max_speed_q) && (right_q <= max_speed_q);

  `PLFS_ASSERT_NXT(a_seg_clears_state, clk_i, rst_ni, seg_hit, state_zero, "state not cleared")
  `PLFS_ASSERT_IMP(a_rem_range, clk_i, rst_ni, 1'b1, rem_ok, "integral remainder out of range")
  `PLFS_ASSERT_IMP(a_ready_when_empty, clk_i, rst_ni, !out_v_q, s_axis_tready_o, "input stalled")
  `PLFS_ASSERT_IMP(a_drive_bound, clk_i, rst_ni, out_v_q, drive_ok, "drive above max speed")

endmodule
